@@ sv/b64e_pkg.sv @@
`default_nettype none

package b64e_pkg;

   // queue depth between the front and the back, a power of two of at least 2
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // ascii codes used by the character map
   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_LOWER_A = 7'h61;
   localparam logic [6:0] CHAR_DIGIT_0 = 7'h30;
   localparam logic [6:0] CHAR_PLUS    = 7'h2B;
   localparam logic [6:0] CHAR_SLASH   = 7'h2F;
   localparam logic [6:0] CHAR_PAD     = 7'h3D;

   // start of each alphabet range, as a sextet value
   localparam logic [5:0] SEXTET_LOWER = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT = 6'd52;
   localparam logic [5:0] SEXTET_PLUS  = 6'd62;

   // one group of up to three bytes, handed from the front to the back
   typedef struct packed {
      logic [23:0] bits;     // zero-filled, first byte in the top bits
      logic [1:0]  n_bytes;  // 1 to 3
      logic        fin;      // group closes the message
   } group_type;

   // sextet to base64 character
   function automatic logic [6:0] b64_char(input logic [5:0] sextet);
      logic [6:0] wide;
      wide = {1'b0, sextet};
      if (sextet < SEXTET_LOWER) begin
         return CHAR_UPPER_A + wide;
      end else if (sextet < SEXTET_DIGIT) begin
         return CHAR_LOWER_A + wide - {1'b0, SEXTET_LOWER};
      end else if (sextet < SEXTET_PLUS) begin
         return CHAR_DIGIT_0 + wide - {1'b0, SEXTET_DIGIT};
      end else if (sextet == SEXTET_PLUS) begin
         return CHAR_PLUS;
      end else begin
         return CHAR_SLASH;
      end
   endfunction

endpackage

`default_nettype wire

@@ sv/b64e_req_if.sv @@
`default_nettype none

interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source(output valid, output data_byte, output final_byte, input ready);
   modport sink(input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

@@ sv/b64e_rsp_if.sv @@
`default_nettype none

interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       end_of_text;

   modport source(output valid, output out_char, output end_of_text, input ready);
   modport sink(input valid, input out_char, input end_of_text, output ready);
endinterface

`default_nettype wire

@@ sv/b64e_front.sv @@
`default_nettype none

module b64e_front (
   input  wire logic                clock,
   input  wire logic                reset,
   b64e_req_if.sink                 req_chan,
   input  wire logic                queue_ready_i,
   output logic                     push_o,
   output b64e_pkg::group_type      group_o
);
   import b64e_pkg::*;

   logic [1:0] pending_count_ff, pending_count_in;
   logic [7:0] pend0_ff, pend0_in;
   logic [7:0] pend1_ff, pend1_in;
   logic       accept;
   logic       closes;

   // a byte is taken whenever the queue has room
   assign req_chan.ready = queue_ready_i;
   assign accept = req_chan.valid && queue_ready_i;
   assign closes = (pending_count_ff == 2'd2) || req_chan.final_byte;
   assign push_o = accept && closes;

   // assemble the group from the pending bytes and the new one
   always_comb begin
      group_o.fin     = req_chan.final_byte;
      group_o.n_bytes = pending_count_ff + 2'd1;
      case (pending_count_ff)
         2'd0: begin
            group_o.bits = {req_chan.data_byte, 16'h0000};
         end
         2'd1: begin
            group_o.bits = {pend0_ff, req_chan.data_byte, 8'h00};
         end
         default: begin
            group_o.bits = {pend0_ff, pend1_ff, req_chan.data_byte};
         end
      endcase
   end

   // pending store update
   always_comb begin
      pending_count_in = pending_count_ff;
      pend0_in         = pend0_ff;
      pend1_in         = pend1_ff;
      if (accept) begin
         if (closes) begin
            pending_count_in = 2'd0;
         end else begin
            pending_count_in = pending_count_ff + 2'd1;
            if (pending_count_ff == 2'd0) begin
               pend0_in = req_chan.data_byte;
            end else begin
               pend1_in = req_chan.data_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_count_ff <= 2'd0;
      end else begin
         pending_count_ff <= pending_count_in;
      end
   end

   // pending bytes carry no reset
   always_ff @(posedge clock) begin
      pend0_ff <= pend0_in;
      pend1_ff <= pend1_in;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      pending_count_ff != 2'd3)
      else $error("pending count out of range");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      accept && !push_o |=> pending_count_ff == $past(pending_count_ff) + 2'd1)
      else $error("pending count did not advance");
   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      push_o |=> pending_count_ff == 2'd0)
      else $error("pending count not cleared after a group");
`endif

endmodule

`default_nettype wire

@@ sv/b64e_queue.sv @@
`default_nettype none

module b64e_queue #(
   parameter int DEPTH = b64e_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_i,
   input  wire b64e_pkg::group_type group_i,
   output logic                     ready_o,
   input  wire logic                pop_i,
   output b64e_pkg::group_type      group_o,
   output logic                     avail_o
);
   import b64e_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   group_type              slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   assign ready_o = (count_ff != CNT_W'(DEPTH));
   assign avail_o = (count_ff != '0);
   assign group_o = slot_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_i) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop_i) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push_i && !pop_i) begin
         count_in = count_ff + 1'b1;
      end else if (pop_i && !push_i) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push_i) begin
         slot_ff[wr_ptr_ff] <= group_i;
      end
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue overfilled");
`endif

endmodule

`default_nettype wire

@@ sv/b64e_back.sv @@
`default_nettype none

module b64e_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                avail_i,
   input  wire b64e_pkg::group_type group_i,
   output logic                     pop_o,
   b64e_rsp_if.source               rsp_chan
);
   import b64e_pkg::*;

   group_type  group_ff, group_in;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [6:0] out_char_ff, out_char_in;
   logic       out_eot_ff, out_eot_in;
   logic       load;
   logic       emit;
   logic [5:0] sextet;

   // output register takes a new character when empty or being drained
   assign load  = !out_valid_ff || rsp_chan.ready;
   assign emit  = load && busy_ff;
   assign pop_o = avail_i && (!busy_ff || (emit && idx_ff == 2'd3));

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.out_char    = out_char_ff;
   assign rsp_chan.end_of_text = out_eot_ff;

   // pick the sextet for the current position, most significant first
   always_comb begin
      case (idx_ff)
         2'd0:    sextet = group_ff.bits[23:18];
         2'd1:    sextet = group_ff.bits[17:12];
         2'd2:    sextet = group_ff.bits[11:6];
         default: sextet = group_ff.bits[5:0];
      endcase
   end

   // group walk, one character per cycle while the output register can load
   always_comb begin
      group_in = group_ff;
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      if (emit) begin
         idx_in = idx_ff + 2'd1;
         if (idx_ff == 2'd3) begin
            busy_in = 1'b0;
         end
      end
      if (pop_o) begin
         group_in = group_i;
         busy_in  = 1'b1;
         idx_in   = 2'd0;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_eot_in   = out_eot_ff;
      if (load) begin
         out_valid_in = busy_ff;
         out_char_in  = ({1'b0, idx_ff} <= {1'b0, group_ff.n_bytes}) ? b64_char(sextet)
                                                                  : CHAR_PAD;
         out_eot_in   = group_ff.fin && (idx_ff == 2'd3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      group_ff    <= group_in;
      out_char_ff <= out_char_in;
      out_eot_ff  <= out_eot_in;
   end

`ifndef SYNTHESIS
   a_walk_step: assert property (@(posedge clock) disable iff (reset)
      emit && idx_ff != 2'd3 |=> busy_ff && idx_ff == $past(idx_ff) + 2'd1)
      else $error("group walk skipped or stopped early");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop_o |-> !busy_ff || idx_ff == 2'd3)
      else $error("new group taken in the middle of a group");
`endif

endmodule

`default_nettype wire

@@ sv/base64_stream_encoder.sv @@
// base64 stream encoder, standard alphabet with '=' padding
//
// req_chan carries one message byte per transfer (data_byte) with final_byte
// set on the last byte of the message. rsp_chan carries one ascii character
// per transfer (out_char); end_of_text marks the last character of a message.
// Both channels use valid/ready; a transfer happens when both are high.
//
// Every third byte, or the final byte, closes a group that yields four
// characters, padded with '=' for a short final group. The group passes
// through the queue and the back end's group register before its first
// character is registered at the output; the back end then emits one
// character per cycle while rsp_chan is ready. req_chan is ready while
// the group queue (QUEUE_DEPTH groups) has room.
//
// When rsp_chan stalls, the output register holds its character, the back
// end waits and the queue fills; req_chan then drops ready.
// Synchronous reset empties the pending store, the queue and the output.
`default_nettype none

module base64_stream_encoder #(
   parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   b64e_req_if.sink    req_chan,
   b64e_rsp_if.source  rsp_chan
);
   import b64e_pkg::*;

   logic      push;
   logic      pop;
   logic      queue_ready;
   logic      queue_avail;
   group_type front_group;
   group_type back_group;

   // byte collection and grouping
   b64e_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .queue_ready_i (queue_ready),
      .push_o        (push),
      .group_o       (front_group)
   );

   // group queue between front and back
   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .group_i (front_group),
      .ready_o (queue_ready),
      .pop_i   (pop),
      .group_o (back_group),
      .avail_o (queue_avail)
   );

   // character generation
   b64e_back u_back (
      .clock    (clock),
      .reset    (reset),
      .avail_i  (queue_avail),
      .group_i  (back_group),
      .pop_o    (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

@@ dv/base64_stream_encoder_test.sv @@
`timescale 1ns / 1ps

module base64_stream_encoder_test;
   import b64e_pkg::*;

   // one message byte as presented on the request channel
   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } msg_byte_type;

   // one encoded character as seen on the response channel
   typedef struct packed {
      logic [6:0] ch;
      logic       eot;
   } enc_char_type;

   localparam int IDLE_LIMIT  = 4000;
   localparam int DRAIN_TICKS = 16;
   localparam int RANDOM_BYTES = 500;

   // standard alphabet, character k in byte 63-k
   localparam logic [8*64-1:0] ALPHABET = {
      "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
      "abcdefghijklmnopqrstuvwxyz",
      "0123456789+/"
   };

   logic clock;
   logic reset;

   b64e_req_if req_chan ();
   b64e_rsp_if rsp_chan ();

   base64_stream_encoder i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   msg_byte_type  bytes_to_send[$];
   enc_char_type  chars_due[$];

   // encoder image: bytes of the open group
   logic [7:0] held_bytes[2];
   int         held_count;

   int   error_count;
   int   idle_cycles;
   logic req_took;
   logic calm;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(8, 40);
      end
   endfunction

   function automatic logic [6:0] sextet_char(input logic [5:0] sx);
      return ALPHABET[8 * (63 - int'(sx)) +: 7];
   endfunction

   // work out the characters caused by one byte transfer
   task automatic encode_byte(input logic [7:0] b, input logic fin);
      logic [7:0]   grp[3];
      logic [5:0]   sx[4];
      enc_char_type c;
      int           n;
      int           k;
      grp[0] = 8'h00;
      grp[1] = 8'h00;
      grp[2] = 8'h00;
      for (n = 0; n < held_count; n++) begin
         grp[n] = held_bytes[n];
      end
      grp[n] = b;
      n = n + 1;
      // group still open: just hold the byte
      if (n < 3 && !fin) begin
         held_bytes[n - 1] = b;
         held_count = n;
         return;
      end
      sx[0] = grp[0][7:2];
      sx[1] = {grp[0][1:0], grp[1][7:4]};
      sx[2] = {grp[1][3:0], grp[2][7:6]};
      sx[3] = grp[2][5:0];
      // n bytes give n+1 characters, the rest is padding
      for (k = 0; k < 4; k++) begin
         c.ch  = (k <= n) ? sextet_char(sx[k]) : CHAR_PAD;
         c.eot = fin && (k == 3);
         chars_due.push_back(c);
      end
      held_count = 0;
   endtask

   function automatic void queue_byte(input logic [7:0] b, input logic fin);
      msg_byte_type m;
      m.data = b;
      m.fin  = fin;
      bytes_to_send.push_back(m);
   endfunction

   function automatic void queue_message(input int len);
      int i;
      for (i = 0; i < len; i++) begin
         queue_byte(8'($urandom_range(0, 255)), i == len - 1);
      end
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // request driver, fed from the byte queue
   always @(negedge clock) begin : req_driver
      int           gap_left;
      msg_byte_type m;
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_left = 0;
      end else if (!req_chan.valid || req_took) begin
         if (gap_left > 0) begin
            req_chan.valid <= 1'b0;
            gap_left = gap_left - 1;
         end else if (bytes_to_send.size() != 0) begin
            m = bytes_to_send.pop_front();
            req_chan.data_byte  <= m.data;
            req_chan.final_byte <= m.fin;
            req_chan.valid      <= 1'b1;
            gap_left = calm ? 0 : pick_gap();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response stalls, with calm stretches that have none
   always @(negedge clock) begin : rsp_driver
      int stall_left;
      int tick;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
         tick = 0;
         calm <= 1'b0;
      end else begin
         tick = tick + 1;
         if (tick % 200 == 0) begin
            calm <= ($urandom_range(0, 2) == 0);
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = stall_left - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) begin
               stall_left = pick_gap();
            end
         end
      end
   end

   // monitor: predict on each byte transfer, check each character transfer
   always @(posedge clock) begin : monitor
      enc_char_type want;
      if (reset) begin
         req_took <= 1'b0;
         idle_cycles = 0;
         held_count = 0;
      end else begin
         req_took <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            encode_byte(req_chan.data_byte, req_chan.final_byte);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (chars_due.size() == 0) begin
               $error("out_char: no character expected, got %h", rsp_chan.out_char);
               error_count++;
            end else begin
               want = chars_due.pop_front();
               if (rsp_chan.out_char !== want.ch) begin
                  $error("out_char: expected %h, got %h", want.ch, rsp_chan.out_char);
                  error_count++;
               end
               if (rsp_chan.end_of_text !== want.eot) begin
                  $error("end_of_text: expected %b, got %b", want.eot,
                         rsp_chan.end_of_text);
                  error_count++;
               end
            end
         end
         // watchdog on cycles without any transfer
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles = idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("base64_stream_encoder regression: fail");
            $finish;
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      int total;
      error_count = 0;
      reset = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.data_byte  = 8'h00;
      req_chan.final_byte = 1'b0;
      rsp_chan.ready      = 1'b0;

      // directed: single byte with double padding, extremes
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);
      // two bytes with single padding
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b1);
      // final byte closing a full group
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b1);
      // full group then one trailing byte
      queue_byte(8'h4D, 1'b0);
      queue_byte(8'h61, 1'b0);
      queue_byte(8'h6E, 1'b0);
      queue_byte(8'hFB, 1'b1);
      // full group then two trailing bytes
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h10, 1'b0);
      queue_byte(8'h83, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFE, 1'b1);
      // two full groups, the second closed by the final byte
      queue_byte(8'hAA, 1'b0);
      queue_byte(8'h55, 1'b0);
      queue_byte(8'h0F, 1'b0);
      queue_byte(8'hF0, 1'b0);
      queue_byte(8'hFC, 1'b0);
      queue_byte(8'h3F, 1'b1);

      // random messages, mostly short, a few long
      total = 0;
      while (total < RANDOM_BYTES) begin : fill
         int len;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                           : $urandom_range(1, 12);
         queue_message(len);
         total = total + len;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all bytes taken, all characters seen, then a short drain
      while (bytes_to_send.size() != 0 || req_chan.valid) @(negedge clock);
      while (chars_due.size() != 0) @(negedge clock);
      repeat (DRAIN_TICKS) @(negedge clock);
      if (chars_due.size() != 0) begin
         $error("out_char: %0d characters never arrived", chars_due.size());
         error_count++;
      end

      if (error_count == 0) begin
         $display("base64_stream_encoder regression: pass");
      end else begin
         $display("base64_stream_encoder regression: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/b64e_pkg.sv
sv/b64e_req_if.sv
sv/b64e_rsp_if.sv
sv/b64e_front.sv
sv/b64e_queue.sv
sv/b64e_back.sv
sv/base64_stream_encoder.sv
dv/base64_stream_encoder_test.sv
